/* design/avgp_pkg.sv */
`timescale 1ns / 1ps
// avgp_pkg: shared constants, register codes and types of the 2x2 average pool
// no dependencies

package avgp_pkg;

  // default sizing, handed to the top level parameters
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // configuration register widths
  localparam int ROW_LEN_W    = 11;
  localparam int PLANE_ROWS_W = 13;
  localparam int OUT_COLS_W   = 10;
  localparam int OUT_ROWS_W   = 12;
  localparam int PAD_W        = 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS   = 3'd5;

  localparam logic [PAD_W-1:0] PAD_MAX = 2'd2;

  // control of the item sitting between the line store read and the output register
  typedef struct packed {
    logic valid;      // item present
    logic emit;       // item completes a window
    logic use_upper;  // window takes the stored upper pair sum
    logic done;       // last window of the plane
  } avgp_op_t;

endpackage

/* design/avg_pool_2x2_stride2.sv */
`timescale 1ns / 1ps
// avg_pool_2x2_stride2: top level of the streaming 2x2 stride-2 average pool
// depends on avgp_pkg, avgp_ctrl, avgp_ram, avgp_out
//
// usage
//   in_*  : one signed sample per item, raster order within a plane, planes back to back
//   out_* : one window average per item, floor(sum / 4), out_tlast on the last of a plane
//   cfg_* : register writes (index 0..5: row length, plane rows, output columns,
//           output rows, row padding, column padding); always ready, write only while
//           the block is idle; a write to index 0..5 restarts the plane position
// throughput: one sample per clock, sustained, with the output side taking items
// a window's completing sample, when taken, loads the op stage and starts the store read;
//   the output register then takes the result from them once it is free
// a window's upper row, unless it is the last row of the plane, leaves its pair sums in a
//   single-port line store of MAX_WIDTH/2+1 entries; the lower row reads them back, so
//   each sample makes at most one store access and no forwarding is needed
// reset: configuration returns to a 1x1 plane without padding, position at the
//   plane start; the line store is not cleared, every read follows a write
// stall: while out_tready is low and a result waits, samples are still taken until the
//   next window-completing sample sits in the op stage; in_tready then stays low
//   until the waiting result leaves

module avg_pool_2x2_stride2
  import avgp_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // sample, zero fill above
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // average, zero fill above
  output logic                  out_tlast   // plane_done
);

  localparam int PW    = SAMPLE_BITS + 1;
  localparam int DEPTH = MAX_WIDTH / 2 + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                   in_accept;
  logic                   op_free;
  logic                   ram_en, ram_we;
  logic [AW-1:0]          ram_addr;
  logic [PW-1:0]          ram_wdata, ram_rdata;
  avgp_op_t               op;
  logic [PW-1:0]          pair;
  logic [SAMPLE_BITS-1:0] avg;

  assign cfg_ready = 1'b1;
  assign in_tready = op_free;
  assign in_accept = in_tvalid && op_free;

  avgp_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_accept (in_accept),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .op_free   (op_free),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .op_r      (op),
    .pair_r    (pair)
  );

  // line store of upper-row pair sums
  avgp_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  avgp_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .pair      (pair),
    .upper_rd  (ram_rdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_avg   (avg),
    .out_done  (out_tlast),
    .op_free   (op_free)
  );

  assign out_tdata = TDATA_W'(avg);

endmodule

/* design/avgp_ram.sv */
`timescale 1ns / 1ps
// avgp_ram: generic single-port synchronous ram with registered read
// no dependencies

module avgp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 513,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/avgp_ctrl.sv */
`timescale 1ns / 1ps
// avgp_ctrl: configuration registers, raster position, pair sums and line store access
// depends on avgp_pkg

module avgp_ctrl
  import avgp_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int PW    = SAMPLE_BITS + 1,
  localparam int DEPTH = MAX_WIDTH / 2 + 1,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_accept,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   op_free,
  output logic                   ram_en,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_addr,
  output logic [PW-1:0]          ram_wdata,
  output avgp_op_t               op_r,
  output logic [PW-1:0]          pair_r
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int MW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (MW > ROW_LEN_W) ? MW : ROW_LEN_W;
  localparam int HW = PLANE_ROWS_W;

  logic [ROW_LEN_W-1:0]    row_len_r;
  logic [PLANE_ROWS_W-1:0] plane_rows_r;
  logic [OUT_COLS_W-1:0]   out_cols_r;
  logic [OUT_ROWS_W-1:0]   out_rows_r;
  logic [PAD_W-1:0]        pad_rows_r;
  logic [PAD_W-1:0]        pad_cols_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [HW-1:0] row_r, row_nxt;
  logic [PW-1:0] pp_nxt;
  avgp_op_t      op_nxt;

  logic [WW-1:0]   w_eff, ow_half, ow_eff, w_ext;
  logic [WW:0]     w_pad_sum;
  logic [HW-1:0]   h_eff, oh_half, oh_eff, h_idx;
  logic [HW:0]     h_pad_sum, rp;
  logic [PAD_W-1:0] pc_eff, pr_eff;
  logic [CW-1:0]   c_cur, w_idx;
  logic [CW:0]     cp;
  logic [HW-1:0]   r_cur;
  logic            col_last, row_last, win_event, wr_upper, use_upper;
  logic [PW-1:0]   s_ext;

  always_comb begin
    // effective sizes after clamping
    if (row_len_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(row_len_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(row_len_r);
    end
    h_eff  = (plane_rows_r == '0) ? HW'(1) : plane_rows_r;
    pc_eff = (pad_cols_r > PAD_MAX) ? PAD_MAX : pad_cols_r;
    pr_eff = (pad_rows_r > PAD_MAX) ? PAD_MAX : pad_rows_r;

    w_pad_sum = {1'b0, w_eff} + (WW+1)'(pc_eff);
    ow_half   = w_pad_sum[WW:1];
    ow_eff    = (WW'(out_cols_r) < ow_half) ? WW'(out_cols_r) : ow_half;
    h_pad_sum = {1'b0, h_eff} + (HW+1)'(pr_eff);
    oh_half   = h_pad_sum[HW:1];
    oh_eff    = (HW'(out_rows_r) < oh_half) ? HW'(out_rows_r) : oh_half;

    // position of this sample, padded coordinates
    c_cur    = (WW'(col_r) >= w_eff) ? '0 : col_r;
    r_cur    = (row_r >= h_eff) ? '0 : row_r;
    cp       = {1'b0, c_cur} + (CW+1)'(pc_eff[1]);
    w_idx    = cp[CW:1];
    w_ext    = WW'(w_idx);
    rp       = {1'b0, r_cur} + (HW+1)'(pr_eff[1]);
    h_idx    = rp[HW:1];
    col_last = (WW'(c_cur) == w_eff - WW'(1));
    row_last = (r_cur == h_eff - HW'(1));

    // running horizontal pair sum
    s_ext = {in_sample[SAMPLE_BITS-1], in_sample};
    if (!cp[0] || c_cur == '0) begin
      pp_nxt = s_ext;
    end else begin
      pp_nxt = pair_r + s_ext;
    end

    win_event = (cp[0] || col_last) && (w_ext < ow_eff) && (h_idx < oh_eff);
    wr_upper  = win_event && !rp[0] && !row_last;
    use_upper = rp[0] && (r_cur != '0);

    op_nxt.valid     = in_accept;
    op_nxt.emit      = win_event && !wr_upper;
    op_nxt.use_upper = use_upper;
    op_nxt.done      = (w_ext == ow_eff - WW'(1)) && (h_idx == oh_eff - HW'(1));

    // raster advance
    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : r_cur + HW'(1);
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end
  end

  // upper row writes its pair sum, lower row reads it back
  assign ram_we    = in_accept && wr_upper;
  assign ram_en    = in_accept && (wr_upper || (op_nxt.emit && use_upper));
  assign ram_addr  = AW'(w_idx);
  assign ram_wdata = pp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r    <= ROW_LEN_W'(1);
      plane_rows_r <= PLANE_ROWS_W'(1);
      out_cols_r   <= OUT_COLS_W'(1);
      out_rows_r   <= OUT_ROWS_W'(1);
      pad_rows_r   <= '0;
      pad_cols_r   <= '0;
      col_r        <= '0;
      row_r        <= '0;
      pair_r       <= '0;
      op_r         <= '0;
    end else begin
      if (cfg_wr && cfg_idx <= REG_PAD_COLS) begin
        case (cfg_idx)
          REG_ROW_LEN:    row_len_r    <= cfg_wdata[ROW_LEN_W-1:0];
          REG_PLANE_ROWS: plane_rows_r <= cfg_wdata[PLANE_ROWS_W-1:0];
          REG_OUT_COLS:   out_cols_r   <= cfg_wdata[OUT_COLS_W-1:0];
          REG_OUT_ROWS:   out_rows_r   <= cfg_wdata[OUT_ROWS_W-1:0];
          REG_PAD_ROWS:   pad_rows_r   <= cfg_wdata[PAD_W-1:0];
          REG_PAD_COLS:   pad_cols_r   <= cfg_wdata[PAD_W-1:0];
          default: ;
        endcase
        // any register write restarts the plane
        col_r  <= '0;
        row_r  <= '0;
        pair_r <= '0;
      end else if (in_accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        pair_r <= pp_nxt;
      end
      if (op_free) begin
        op_r <= op_nxt;
      end
    end
  end

  a_wr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !op_nxt.emit)
    else $error("line store written by an item that completes a window");

  a_read_reaches_op: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_en && !ram_we) |=> (op_r.valid && op_r.emit && op_r.use_upper))
    else $error("line store read without a matching item in the output stage");

  a_store_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ram_en |-> op_free)
    else $error("line store accessed while the output stage is stalled");

endmodule

/* design/avgp_out.sv */
`timescale 1ns / 1ps
// avgp_out: adds the stored upper pair sum, floor divides by four, output register
// depends on avgp_pkg

module avgp_out
  import avgp_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  localparam int PW = SAMPLE_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  avgp_op_t               op,
  input  logic [PW-1:0]          pair,
  input  logic [PW-1:0]          upper_rd,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_avg,
  output logic                   out_done,
  output logic                   op_free
);

  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic                   done_r;
  logic [PW-1:0]          upper;
  logic [PW:0]            sum;
  logic                   load;

  assign upper   = op.use_upper ? upper_rd : '0;
  assign sum     = {upper[PW-1], upper} + {pair[PW-1], pair};
  assign op_free = !op.valid || !op.emit || !out_valid_r || out_ready;
  assign load    = op.valid && op.emit && op_free;

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      // dropping the two low bits is floor division for two's complement
      avg_r  <= sum[PW:2];
      done_r <= op.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_avg   = avg_r;
  assign out_done  = done_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("window result not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !(op.valid && op.emit)) |=> !out_valid_r)
    else $error("taken result presented again");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(avg_r) && $stable(done_r)))
    else $error("waiting result changed before it was taken");

endmodule
